// ===== sv/smbhc_pkg.sv =====
`timescale 1ns / 1ps

package smbhc_pkg;

  localparam int BLOCK_DEPTH_DEF   = 32;
  localparam int MAX_BLOCK_LEN_DEF = 32;
  localparam int DEVICE_SLOTS_DEF  = 4;
  localparam int MAX_RESULTS       = 32;
  localparam int NUM_DEV           = 4;
  localparam int LEN_W             = 6;
  localparam int CFG_IDX_W         = 3;

  // entry 0 is the first device
  localparam logic [NUM_DEV-1:0][6:0] DEV_ADDR_RST = {7'h45, 7'h4C, 7'h10, 7'h54};

  localparam logic [5:0] ST_ABORT = 6'h01;
  localparam logic [5:0] ST_PRERR = 6'h04;
  localparam logic [5:0] ST_DONE  = 6'h10;
  localparam logic [5:0] ST_CLEAR = 6'h37;
  localparam logic [7:0] ST_BUSY  = 8'h08;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RESP  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_STATUS  = 3'd0,
    REG_CONTROL = 3'd1,
    REG_ADDR    = 3'd2,
    REG_CMD     = 3'd3,
    REG_DATA0   = 3'd4,
    REG_DATA1   = 3'd5,
    REG_BLOCK   = 3'd6,
    REG_NONE    = 3'd7
  } reg_sel_t;

  typedef enum logic [2:0] {
    CYC_QUICK     = 3'd0,
    CYC_BYTE      = 3'd1,
    CYC_BYTE_DATA = 3'd2,
    CYC_WORD      = 3'd3,
    CYC_CALL      = 3'd4,
    CYC_BLOCK     = 3'd5
  } cyc_t;

  typedef enum logic [3:0] {
    OP_QUICK_WR = 4'd0,
    OP_QUICK_RD = 4'd1,
    OP_SEND     = 4'd2,
    OP_RECV     = 4'd3,
    OP_WR_BYTE  = 4'd4,
    OP_RD_BYTE  = 4'd5,
    OP_WR_WORD  = 4'd6,
    OP_RD_WORD  = 4'd7,
    OP_CALL     = 4'd8
  } op_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        req_valid;
    logic [3:0]  req_op;
    logic [6:0]  req_addr;
    logic [7:0]  req_cmd;
    logic [15:0] req_data;
    logic        irq;
    logic        bad_write;
    logic        last;
  } res_t;

  typedef struct packed {
    logic             load;
    logic [LEN_W-1:0] len;
    logic [7:0]       cmd;
  } burst_t;

  typedef struct packed {
    logic       we;
    logic       clr;
    logic [7:0] wdata;
  } bbuf_ctl_t;

endpackage

// ===== sv/smbhc_bbuf.sv =====
`timescale 1ns / 1ps

module smbhc_bbuf #(
  parameter int BLOCK_DEPTH = smbhc_pkg::BLOCK_DEPTH_DEF,
  localparam int AW = $clog2(BLOCK_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  smbhc_pkg::bbuf_ctl_t ctl,
  input  logic [AW-1:0]        waddr,
  input  logic [AW-1:0]        raddr,
  output logic [7:0]           rdata
);

  logic [7:0]             mem_r [BLOCK_DEPTH];
  logic [BLOCK_DEPTH-1:0] valid_r;
  logic [7:0]             rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem_r[waddr] <= ctl.wdata;
    end
  end

  // entries not written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.clr) begin
      valid_r <= '0;
    end else if (ctl.we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdata_r <= '0;
    end else if (ctl.clr) begin
      rdata_r <= '0;
    end else if (ctl.we && (waddr == raddr)) begin
      rdata_r <= ctl.wdata;
    end else if (valid_r[raddr]) begin
      rdata_r <= mem_r[raddr];
    end else begin
      rdata_r <= '0;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/smbhc_core.sv =====
`timescale 1ns / 1ps

module smbhc_core #(
  parameter int BLOCK_DEPTH   = smbhc_pkg::BLOCK_DEPTH_DEF,
  parameter int MAX_BLOCK_LEN = smbhc_pkg::MAX_BLOCK_LEN_DEF,
  parameter int DEVICE_SLOTS  = smbhc_pkg::DEVICE_SLOTS_DEF,
  localparam int AW = $clog2(BLOCK_DEPTH)
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         go,
  input  logic [1:0]                                   kind,
  input  logic [2:0]                                   sel,
  input  logic [7:0]                                   wdata,
  input  logic                                         resp_ok,
  input  logic [15:0]                                  resp_data,
  input  logic [smbhc_pkg::NUM_DEV-1:0][6:0]           dev_addr,
  input  logic [7:0]                                   buf_rd,
  output smbhc_pkg::res_t                              res,
  output logic                                         emit,
  output smbhc_pkg::burst_t                            bload,
  output logic [AW-1:0]                                baddr,
  output smbhc_pkg::bbuf_ctl_t                         bctl,
  output logic [AW-1:0]                                bwaddr,
  output logic [AW-1:0]                                ptr_next,
  output logic [7:0]                                   target,
  output logic                                         irq
);

  localparam int LEN_MAX    = (MAX_BLOCK_LEN < smbhc_pkg::MAX_RESULTS) ?
                              MAX_BLOCK_LEN : smbhc_pkg::MAX_RESULTS;
  localparam int MOD_STEPS  = LEN_MAX / BLOCK_DEPTH;
  localparam int SLOTS_USED = (DEVICE_SLOTS < smbhc_pkg::NUM_DEV) ?
                              DEVICE_SLOTS : smbhc_pkg::NUM_DEV;

  logic [5:0]                  status_r, status_nxt;
  logic [2:0]                  ctype_r, ctype_nxt;
  logic                        en_r, en_nxt;
  logic [7:0]                  target_r, target_nxt;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [7:0]                  dlo_r, dlo_nxt;
  logic [7:0]                  dhi_r, dhi_nxt;
  logic [AW-1:0]               ptr_r, ptr_nxt;
  logic                        irq_r, irq_nxt;
  logic [smbhc_pkg::LEN_W-1:0] left_r, left_nxt;
  logic [AW-1:0]               bstart_r, bstart_nxt;
  logic                        ok_r, ok_nxt;
  logic                        busy_r, busy_nxt;

  logic [AW-1:0]               ptr_inc;
  logic [AW-1:0]               bstart_inc;
  logic                        present;
  logic                        rd;
  logic [6:0]                  hw;
  logic [smbhc_pkg::LEN_W-1:0] blen;
  logic [8:0]                  lmod;
  logic [8:0]                  p9;
  logic [8:0]                  s9;
  logic [AW-1:0]               wr_start;
  logic [15:0]                 word;

  assign hw   = target_r[7:1];
  assign rd   = target_r[0];
  assign word = {dhi_r, dlo_r};

  assign ptr_inc    = (ptr_r == AW'(BLOCK_DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign bstart_inc = (bstart_r == AW'(BLOCK_DEPTH - 1)) ? '0 : bstart_r + 1'b1;

  always_comb begin
    present = 1'b0;
    for (int i = 0; i < SLOTS_USED; i++) begin
      if (dev_addr[i] == hw) begin
        present = 1'b1;
      end
    end
  end

  // block length and the start of the entries just below the pointer
  always_comb begin
    blen = (dlo_r > 8'(LEN_MAX)) ? smbhc_pkg::LEN_W'(LEN_MAX) : dlo_r[smbhc_pkg::LEN_W-1:0];
    lmod = 9'(blen);
    for (int k = 0; k < MOD_STEPS; k++) begin
      if (lmod >= 9'(BLOCK_DEPTH)) begin
        lmod = lmod - 9'(BLOCK_DEPTH);
      end
    end
    p9 = 9'(ptr_r);
    s9 = (p9 >= lmod) ? (p9 - lmod) : (p9 + 9'(BLOCK_DEPTH) - lmod);
    wr_start = s9[AW-1:0];
  end

  always_comb begin
    logic       bad;
    logic       fin;
    logic       ok_acc;
    logic [smbhc_pkg::LEN_W-1:0] left_dec;

    status_nxt = status_r;
    ctype_nxt  = ctype_r;
    en_nxt     = en_r;
    target_nxt = target_r;
    cmd_nxt    = cmd_r;
    dlo_nxt    = dlo_r;
    dhi_nxt    = dhi_r;
    ptr_nxt    = ptr_r;
    irq_nxt    = irq_r;
    left_nxt   = left_r;
    bstart_nxt = bstart_r;
    ok_nxt     = ok_r;
    busy_nxt   = busy_r;

    res      = '0;
    emit     = 1'b0;
    bload    = '0;
    baddr    = wr_start;
    bctl     = '0;
    bwaddr   = ptr_r;
    bad      = 1'b0;
    fin      = 1'b0;
    ok_acc   = ok_r & resp_ok;
    left_dec = (left_r != '0) ? left_r - 1'b1 : '0;

    if (go) begin
      emit = 1'b1;
      case (smbhc_pkg::kind_t'(kind))
        smbhc_pkg::KIND_READ: begin
          case (smbhc_pkg::reg_sel_t'(sel))
            smbhc_pkg::REG_STATUS:
              res.rdata = {2'b00, status_r & smbhc_pkg::ST_CLEAR} |
                          (busy_r ? smbhc_pkg::ST_BUSY : 8'h00);
            smbhc_pkg::REG_CONTROL: res.rdata = {3'b000, en_r, 1'b0, ctype_r};
            smbhc_pkg::REG_ADDR:    res.rdata = target_r;
            smbhc_pkg::REG_CMD:     res.rdata = cmd_r;
            smbhc_pkg::REG_DATA0:   res.rdata = dlo_r;
            smbhc_pkg::REG_DATA1:   res.rdata = dhi_r;
            smbhc_pkg::REG_BLOCK: begin
              res.rdata = buf_rd;
              ptr_nxt   = ptr_inc;
            end
            default: res.rdata = 8'h00;
          endcase
        end
        smbhc_pkg::KIND_WRITE: begin
          case (smbhc_pkg::reg_sel_t'(sel))
            smbhc_pkg::REG_STATUS: begin
              if (en_r && |(wdata[5:0] & smbhc_pkg::ST_CLEAR & status_r)) begin
                irq_nxt = 1'b0;
              end
              status_nxt = status_r & ~(wdata[5:0] & smbhc_pkg::ST_CLEAR);
            end
            smbhc_pkg::REG_CONTROL: begin
              en_nxt = wdata[4];
              if (!busy_r) begin
                ctype_nxt = wdata[2:0];
              end
              if (wdata[5]) begin
                // abort wins over start
                status_nxt = status_r | smbhc_pkg::ST_ABORT;
                busy_nxt   = 1'b0;
                left_nxt   = '0;
                if (wdata[4]) begin
                  irq_nxt = 1'b1;
                end
              end else if (wdata[3] && !busy_r) begin
                if (!present) begin
                  status_nxt = status_r | smbhc_pkg::ST_PRERR;
                  if (wdata[4]) begin
                    irq_nxt = 1'b1;
                  end
                end else begin
                  case (smbhc_pkg::cyc_t'(wdata[2:0]))
                    smbhc_pkg::CYC_QUICK: begin
                      res.req_valid = 1'b1;
                      res.req_op    = rd ? smbhc_pkg::OP_QUICK_RD : smbhc_pkg::OP_QUICK_WR;
                    end
                    smbhc_pkg::CYC_BYTE: begin
                      res.req_valid = 1'b1;
                      res.req_op    = rd ? smbhc_pkg::OP_RECV : smbhc_pkg::OP_SEND;
                      res.req_cmd   = rd ? 8'h00 : cmd_r;
                    end
                    smbhc_pkg::CYC_BYTE_DATA: begin
                      res.req_valid = 1'b1;
                      res.req_op    = rd ? smbhc_pkg::OP_RD_BYTE : smbhc_pkg::OP_WR_BYTE;
                      res.req_cmd   = cmd_r;
                      res.req_data  = rd ? 16'h0000 : {8'h00, dlo_r};
                    end
                    smbhc_pkg::CYC_WORD: begin
                      res.req_valid = 1'b1;
                      res.req_op    = rd ? smbhc_pkg::OP_RD_WORD : smbhc_pkg::OP_WR_WORD;
                      res.req_cmd   = cmd_r;
                      res.req_data  = rd ? 16'h0000 : word;
                    end
                    smbhc_pkg::CYC_CALL: begin
                      res.req_valid = 1'b1;
                      res.req_op    = smbhc_pkg::OP_CALL;
                      res.req_cmd   = cmd_r;
                      res.req_data  = word;
                    end
                    smbhc_pkg::CYC_BLOCK: begin
                      ok_nxt     = 1'b1;
                      bstart_nxt = rd ? ptr_r : wr_start;
                      if (blen == '0) begin
                        status_nxt = status_r | smbhc_pkg::ST_DONE;
                        busy_nxt   = 1'b0;
                        left_nxt   = '0;
                        if (wdata[4]) begin
                          irq_nxt = 1'b1;
                        end
                      end else begin
                        busy_nxt   = 1'b1;
                        left_nxt   = blen;
                        emit       = 1'b0;
                        bload.load = 1'b1;
                        bload.len  = blen;
                        bload.cmd  = cmd_r;
                      end
                    end
                    default: ;
                  endcase
                  if (res.req_valid) begin
                    res.req_addr = hw;
                    ok_nxt       = 1'b1;
                    busy_nxt     = 1'b1;
                    left_nxt     = smbhc_pkg::LEN_W'(1);
                  end
                end
              end
            end
            smbhc_pkg::REG_ADDR:  if (!busy_r) target_nxt = wdata;
            smbhc_pkg::REG_CMD:   if (!busy_r) cmd_nxt = wdata;
            smbhc_pkg::REG_DATA0: if (!busy_r) dlo_nxt = wdata;
            smbhc_pkg::REG_DATA1: if (!busy_r) dhi_nxt = wdata;
            smbhc_pkg::REG_BLOCK: begin
              bctl.we    = 1'b1;
              bctl.wdata = wdata;
              bwaddr     = ptr_r;
              ptr_nxt    = ptr_inc;
            end
            default: bad = 1'b1;
          endcase
        end
        smbhc_pkg::KIND_RESP: begin
          if (busy_r) begin
            ok_nxt = ok_acc;
            if (ctype_r == smbhc_pkg::CYC_BLOCK) begin
              if (rd) begin
                bctl.we    = 1'b1;
                bctl.wdata = resp_data[7:0];
                bwaddr     = bstart_r;
                bstart_nxt = bstart_inc;
              end
              left_nxt = left_dec;
              fin      = (left_dec == '0);
            end else begin
              if (ok_acc) begin
                if ((ctype_r == smbhc_pkg::CYC_BYTE || ctype_r == smbhc_pkg::CYC_BYTE_DATA)
                    && rd) begin
                  dlo_nxt = resp_data[7:0];
                end else if ((ctype_r == smbhc_pkg::CYC_WORD && rd) ||
                             ctype_r == smbhc_pkg::CYC_CALL) begin
                  dlo_nxt = resp_data[7:0];
                  dhi_nxt = resp_data[15:8];
                end
              end
              fin = 1'b1;
            end
            if (fin) begin
              busy_nxt = 1'b0;
              left_nxt = '0;
              if (ok_acc) begin
                status_nxt = status_r | smbhc_pkg::ST_DONE;
              end else begin
                if (ctype_r == smbhc_pkg::CYC_BLOCK) begin
                  bctl.clr = 1'b1;
                end
                status_nxt = status_r | smbhc_pkg::ST_PRERR;
              end
              if (en_r) begin
                irq_nxt = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      res.irq       = irq_nxt;
      res.bad_write = bad;
      res.last      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= '0;
      ctype_r  <= '0;
      en_r     <= 1'b0;
      target_r <= '0;
      cmd_r    <= '0;
      dlo_r    <= '0;
      dhi_r    <= '0;
      ptr_r    <= '0;
      irq_r    <= 1'b0;
      left_r   <= '0;
      bstart_r <= '0;
      ok_r     <= 1'b1;
      busy_r   <= 1'b0;
    end else begin
      status_r <= status_nxt;
      ctype_r  <= ctype_nxt;
      en_r     <= en_nxt;
      target_r <= target_nxt;
      cmd_r    <= cmd_nxt;
      dlo_r    <= dlo_nxt;
      dhi_r    <= dhi_nxt;
      ptr_r    <= ptr_nxt;
      irq_r    <= irq_nxt;
      left_r   <= left_nxt;
      bstart_r <= bstart_nxt;
      ok_r     <= ok_nxt;
      busy_r   <= busy_nxt;
    end
  end

  assign ptr_next = ptr_nxt;
  assign target   = target_r;
  assign irq      = irq_r;

endmodule

// ===== sv/smbhc_burst.sv =====
`timescale 1ns / 1ps

module smbhc_burst #(
  parameter int BLOCK_DEPTH = smbhc_pkg::BLOCK_DEPTH_DEF,
  localparam int AW = $clog2(BLOCK_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  smbhc_pkg::burst_t bload,
  input  logic [AW-1:0]     baddr,
  input  logic              out_free,
  input  logic [7:0]        target,
  input  logic              irq,
  input  logic [7:0]        buf_rd,
  output logic              act,
  output logic              fire,
  output logic              act_next,
  output logic [AW-1:0]     addr_next,
  output smbhc_pkg::res_t   res
);

  logic [smbhc_pkg::LEN_W-1:0] left_r, left_nxt;
  logic [7:0]                  cmd_r, cmd_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;

  assign act  = (left_r != '0);
  assign fire = act && out_free;

  always_comb begin
    left_nxt = left_r;
    cmd_nxt  = cmd_r;
    addr_nxt = addr_r;
    if (bload.load) begin
      left_nxt = bload.len;
      cmd_nxt  = bload.cmd;
      addr_nxt = baddr;
    end else if (fire) begin
      left_nxt = left_r - 1'b1;
      cmd_nxt  = cmd_r + 1'b1;
      addr_nxt = (addr_r == AW'(BLOCK_DEPTH - 1)) ? '0 : addr_r + 1'b1;
    end
  end

  assign act_next  = (left_nxt != '0);
  assign addr_next = addr_nxt;

  always_comb begin
    res           = '0;
    res.req_valid = 1'b1;
    res.req_op    = target[0] ? smbhc_pkg::OP_RD_BYTE : smbhc_pkg::OP_WR_BYTE;
    res.req_addr  = target[7:1];
    res.req_cmd   = cmd_r;
    res.req_data  = target[0] ? 16'h0000 : {8'h00, buf_rd};
    res.irq       = irq;
    res.last      = (left_r == smbhc_pkg::LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      cmd_r  <= '0;
      addr_r <= '0;
    end else begin
      left_r <= left_nxt;
      cmd_r  <= cmd_nxt;
      addr_r <= addr_nxt;
    end
  end

endmodule

// ===== sv/smbus_host_controller.sv =====
`timescale 1ns / 1ps

// SMBus host controller register block. Each input transaction (register read,
// register write or device response) is registered, processed combinationally and
// its result is registered on the out_ channel, so single-result transactions
// flow at one per cycle while the out_ channel is not stalled. Starting a block
// cycle of length n loads the burst issuer, which then issues its n byte
// requests at one per cycle while out_ is not stalled, the write data coming
// from the block buffer's registered read port; while they go out, one more
// transaction can wait in the input register and no further one is accepted
// until the last request has been issued. The block buffer is cleared through
// per-entry valid bits, so there is no clearing pass after reset. Device
// addresses are written through the cfg_ port, which is always ready; writes to
// indexes past the fourth are dropped.
module smbus_host_controller #(
  parameter int BLOCK_DEPTH   = smbhc_pkg::BLOCK_DEPTH_DEF,
  parameter int MAX_BLOCK_LEN = smbhc_pkg::MAX_BLOCK_LEN_DEF,
  parameter int DEVICE_SLOTS  = smbhc_pkg::DEVICE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [2:0]                      in_reg_sel,
  input  logic [7:0]                      in_wdata,
  input  logic                            in_resp_ok,
  input  logic [15:0]                     in_resp_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_rdata,
  output logic                            out_req_valid,
  output logic [3:0]                      out_req_op,
  output logic [6:0]                      out_req_addr,
  output logic [7:0]                      out_req_cmd,
  output logic [15:0]                     out_req_data,
  output logic                            out_irq,
  output logic                            out_bad_write,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [smbhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]                      cfg_wdata
);

  localparam int AW = $clog2(BLOCK_DEPTH);

  logic                                   in_v_r;
  logic [1:0]                             kind_r;
  logic [2:0]                             sel_r;
  logic [7:0]                             wdata_r;
  logic                                   resp_ok_r;
  logic [15:0]                            resp_data_r;
  logic                                   out_v_r, out_v_nxt;
  smbhc_pkg::res_t                        out_r, out_nxt;
  logic [smbhc_pkg::NUM_DEV-1:0][6:0]     dev_addr_r;

  logic                                   out_free;
  logic                                   core_go;
  smbhc_pkg::res_t                        core_res;
  logic                                   core_emit;
  smbhc_pkg::burst_t                      bload;
  logic [AW-1:0]                          baddr;
  smbhc_pkg::bbuf_ctl_t                   bctl;
  logic [AW-1:0]                          bwaddr;
  logic [AW-1:0]                          ptr_next;
  logic [7:0]                             target;
  logic                                   irq;
  logic [7:0]                             buf_rd;
  logic                                   burst_act;
  logic                                   burst_fire;
  logic                                   burst_act_next;
  logic [AW-1:0]                          burst_addr_next;
  smbhc_pkg::res_t                        burst_res;
  logic [AW-1:0]                          rd_addr;

  assign out_free  = !out_v_r || out_ready;
  assign core_go   = in_v_r && !burst_act && out_free;
  assign in_ready  = !in_v_r || core_go;
  assign cfg_ready = 1'b1;
  assign rd_addr   = burst_act_next ? burst_addr_next : ptr_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= smbhc_pkg::DEV_ADDR_RST;
    end else if (cfg_valid && (cfg_index < smbhc_pkg::CFG_IDX_W'(smbhc_pkg::NUM_DEV))) begin
      dev_addr_r[cfg_index[1:0]] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (core_go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r      <= in_kind;
      sel_r       <= in_reg_sel;
      wdata_r     <= in_wdata;
      resp_ok_r   <= in_resp_ok;
      resp_data_r <= in_resp_data;
    end
  end

  smbhc_core #(
    .BLOCK_DEPTH  (BLOCK_DEPTH),
    .MAX_BLOCK_LEN(MAX_BLOCK_LEN),
    .DEVICE_SLOTS (DEVICE_SLOTS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (core_go),
    .kind     (kind_r),
    .sel      (sel_r),
    .wdata    (wdata_r),
    .resp_ok  (resp_ok_r),
    .resp_data(resp_data_r),
    .dev_addr (dev_addr_r),
    .buf_rd   (buf_rd),
    .res      (core_res),
    .emit     (core_emit),
    .bload    (bload),
    .baddr    (baddr),
    .bctl     (bctl),
    .bwaddr   (bwaddr),
    .ptr_next (ptr_next),
    .target   (target),
    .irq      (irq)
  );

  smbhc_bbuf #(
    .BLOCK_DEPTH(BLOCK_DEPTH)
  ) u_bbuf (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (bctl),
    .waddr(bwaddr),
    .raddr(rd_addr),
    .rdata(buf_rd)
  );

  smbhc_burst #(
    .BLOCK_DEPTH(BLOCK_DEPTH)
  ) u_burst (
    .clk      (clk),
    .rst_n    (rst_n),
    .bload    (bload),
    .baddr    (baddr),
    .out_free (out_free),
    .target   (target),
    .irq      (irq),
    .buf_rd   (buf_rd),
    .act      (burst_act),
    .fire     (burst_fire),
    .act_next (burst_act_next),
    .addr_next(burst_addr_next),
    .res      (burst_res)
  );

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (core_go && core_emit) begin
      out_v_nxt = 1'b1;
      out_nxt   = core_res;
    end else if (burst_fire) begin
      out_v_nxt = 1'b1;
      out_nxt   = burst_res;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid     = out_v_r;
  assign out_rdata     = out_r.rdata;
  assign out_req_valid = out_r.req_valid;
  assign out_req_op    = out_r.req_op;
  assign out_req_addr  = out_r.req_addr;
  assign out_req_cmd   = out_r.req_cmd;
  assign out_req_data  = out_r.req_data;
  assign out_irq       = out_r.irq;
  assign out_bad_write = out_r.bad_write;
  assign out_last      = out_r.last;

`ifndef SYNTHESIS
  a_burst_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |->
      out_req_valid && (out_req_op == smbhc_pkg::OP_RD_BYTE ||
                        out_req_op == smbhc_pkg::OP_WR_BYTE))
    else $error("non-final result is not a block byte request");

  a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rdata != 8'h00) |-> !out_req_valid && out_last)
    else $error("register read data on a request result");

  a_stall_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && burst_act |-> !in_ready)
    else $error("input taken while a block transaction is issuing");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap before the final block request");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import smbhc_pkg::*;

  localparam int STALL_LIMIT = 3000;

  localparam logic [1:0] KIND_OTHER = 2'd3;
  localparam logic [7:0] CTL_START  = 8'h08;
  localparam logic [7:0] CTL_EN     = 8'h10;
  localparam logic [7:0] CTL_ABORT  = 8'h20;
  localparam logic [2:0] CYC_RSVD6  = 3'd6;
  localparam logic [2:0] CYC_RSVD7  = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = '0;
  logic [2:0] in_reg_sel = '0;
  logic [7:0] in_wdata = '0;
  logic in_resp_ok = 1'b0;
  logic [15:0] in_resp_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_rdata;
  logic out_req_valid;
  logic [3:0] out_req_op;
  logic [6:0] out_req_addr;
  logic [7:0] out_req_cmd;
  logic [15:0] out_req_data;
  logic out_irq;
  logic out_bad_write;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [6:0] cfg_wdata = '0;

  int in_idle_pct = 12;
  int out_idle_pct = 69;
  int items_sent = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  // host controller shadow state
  logic [6:0] dev_tab [NUM_DEV];
  logic [5:0] hc_status;
  logic [2:0] hc_type;
  logic hc_en;
  logic [7:0] hc_target, hc_cmd, hc_dlo, hc_dhi;
  logic [7:0] hc_blk [BLOCK_DEPTH_DEF];
  logic [4:0] hc_ptr, hc_fill;
  int hc_left;
  logic hc_irq, hc_ok, hc_busy;

  res_t cycle_reqs[$];
  res_t host_results_due[$];
  res_t due_res;

  smbus_host_controller u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_reg_sel   (in_reg_sel),
    .in_wdata     (in_wdata),
    .in_resp_ok   (in_resp_ok),
    .in_resp_data (in_resp_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rdata    (out_rdata),
    .out_req_valid(out_req_valid),
    .out_req_op   (out_req_op),
    .out_req_addr (out_req_addr),
    .out_req_cmd  (out_req_cmd),
    .out_req_data (out_req_data),
    .out_irq      (out_irq),
    .out_bad_write(out_bad_write),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic reset_host_shadow();
    foreach (dev_tab[i]) dev_tab[i] = DEV_ADDR_RST[i];
    foreach (hc_blk[i]) hc_blk[i] = '0;
    hc_status = '0;
    hc_type = '0;
    hc_en = 1'b0;
    hc_target = '0;
    hc_cmd = '0;
    hc_dlo = '0;
    hc_dhi = '0;
    hc_ptr = '0;
    hc_fill = '0;
    hc_left = 0;
    hc_irq = 1'b0;
    hc_ok = 1'b1;
    hc_busy = 1'b0;
  endtask

  function automatic res_t bus_request(op_t op, logic [7:0] cmd, logic [15:0] data);
    res_t r;
    r = '0;
    r.req_valid = 1'b1;
    r.req_op = op;
    r.req_addr = hc_target[7:1];
    r.req_cmd = cmd;
    r.req_data = data;
    return r;
  endfunction

  task automatic end_bus_cycle(logic ok);
    hc_busy = 1'b0;
    hc_left = 0;
    if (ok) begin
      hc_status |= ST_DONE;
    end else begin
      if (hc_type == CYC_BLOCK) foreach (hc_blk[i]) hc_blk[i] = '0;
      hc_status |= ST_PRERR;
    end
    if (hc_en) hc_irq = 1'b1;
  endtask

  task automatic launch_bus_cycle();
    logic [6:0] hw;
    logic rd;
    logic [15:0] word;
    logic present;
    int len;
    logic [4:0] s;
    hw = hc_target[7:1];
    rd = hc_target[0];
    word = {hc_dhi, hc_dlo};
    present = 1'b0;
    foreach (dev_tab[i]) if (dev_tab[i] == hw) present = 1'b1;
    if (!present) begin
      hc_status |= ST_PRERR;
      if (hc_en) hc_irq = 1'b1;
      return;
    end
    case (hc_type)
      CYC_QUICK: cycle_reqs.push_back(bus_request(rd ? OP_QUICK_RD : OP_QUICK_WR, 8'h00, 16'h0));
      CYC_BYTE: begin
        if (rd) cycle_reqs.push_back(bus_request(OP_RECV, 8'h00, 16'h0));
        else cycle_reqs.push_back(bus_request(OP_SEND, hc_cmd, 16'h0));
      end
      CYC_BYTE_DATA: begin
        if (rd) cycle_reqs.push_back(bus_request(OP_RD_BYTE, hc_cmd, 16'h0));
        else cycle_reqs.push_back(bus_request(OP_WR_BYTE, hc_cmd, {8'h00, hc_dlo}));
      end
      CYC_WORD: begin
        if (rd) cycle_reqs.push_back(bus_request(OP_RD_WORD, hc_cmd, 16'h0));
        else cycle_reqs.push_back(bus_request(OP_WR_WORD, hc_cmd, word));
      end
      CYC_CALL: cycle_reqs.push_back(bus_request(OP_CALL, hc_cmd, word));
      CYC_BLOCK: begin
        len = (int'(hc_dlo) > MAX_BLOCK_LEN_DEF) ? MAX_BLOCK_LEN_DEF : int'(hc_dlo);
        if (len > MAX_RESULTS) len = MAX_RESULTS;
        s = hc_ptr - len[4:0];
        for (int i = 0; i < len; i++) begin
          if (rd) cycle_reqs.push_back(bus_request(OP_RD_BYTE, hc_cmd + i[7:0], 16'h0));
          else cycle_reqs.push_back(bus_request(OP_WR_BYTE, hc_cmd + i[7:0],
                                                {8'h00, hc_blk[s + i[4:0]]}));
        end
        hc_fill = rd ? hc_ptr : s;
        hc_ok = 1'b1;
        if (len == 0) begin
          end_bus_cycle(1'b1);
        end else begin
          hc_busy = 1'b1;
          hc_left = len;
        end
        return;
      end
      default: return;
    endcase
    hc_ok = 1'b1;
    hc_busy = 1'b1;
    hc_left = 1;
  endtask

  task automatic take_device_response(logic ok, logic [15:0] data);
    logic rd;
    rd = hc_target[0];
    if (!hc_busy) return;
    hc_ok = hc_ok && ok;
    if (hc_type == CYC_BLOCK) begin
      if (rd) begin
        hc_blk[hc_fill] = data[7:0];
        hc_fill++;
      end
      if (hc_left > 0) hc_left--;
      if (hc_left == 0) end_bus_cycle(hc_ok);
      return;
    end
    if (hc_ok) begin
      if ((hc_type == CYC_BYTE || hc_type == CYC_BYTE_DATA) && rd) begin
        hc_dlo = data[7:0];
      end else if ((hc_type == CYC_WORD && rd) || hc_type == CYC_CALL) begin
        {hc_dhi, hc_dlo} = data;
      end
    end
    end_bus_cycle(hc_ok);
  endtask

  task automatic predict_host_step(logic [1:0] kind, logic [2:0] sel, logic [7:0] w,
                                   logic ok, logic [15:0] data);
    logic [7:0] rd_val;
    logic bad;
    res_t r;
    rd_val = '0;
    bad = 1'b0;
    cycle_reqs.delete();
    case (kind)
      KIND_READ: begin
        case (sel)
          REG_STATUS: rd_val = {2'b00, hc_status & ST_CLEAR} | (hc_busy ? ST_BUSY : 8'h00);
          REG_CONTROL: rd_val = {3'b000, hc_en, 1'b0, hc_type};
          REG_ADDR: rd_val = hc_target;
          REG_CMD: rd_val = hc_cmd;
          REG_DATA0: rd_val = hc_dlo;
          REG_DATA1: rd_val = hc_dhi;
          REG_BLOCK: begin
            rd_val = hc_blk[hc_ptr];
            hc_ptr++;
          end
          default: rd_val = '0;
        endcase
      end
      KIND_WRITE: begin
        case (sel)
          REG_STATUS: begin
            if (hc_en && (w[5:0] & ST_CLEAR & hc_status) != 0) hc_irq = 1'b0;
            hc_status = hc_status & ~(w[5:0] & ST_CLEAR);
          end
          REG_CONTROL: begin
            hc_en = w[4];
            if (!hc_busy) hc_type = w[2:0];
            if ((w & CTL_ABORT) != 0) begin
              hc_status |= ST_ABORT;
              hc_busy = 1'b0;
              hc_left = 0;
              if (hc_en) hc_irq = 1'b1;
            end else if ((w & CTL_START) != 0 && !hc_busy) begin
              launch_bus_cycle();
            end
          end
          REG_ADDR: if (!hc_busy) hc_target = w;
          REG_CMD: if (!hc_busy) hc_cmd = w;
          REG_DATA0: if (!hc_busy) hc_dlo = w;
          REG_DATA1: if (!hc_busy) hc_dhi = w;
          REG_BLOCK: begin
            hc_blk[hc_ptr] = w;
            hc_ptr++;
          end
          default: bad = 1'b1;
        endcase
      end
      KIND_RESP: take_device_response(ok, data);
      default: ;
    endcase
    if (cycle_reqs.size() == 0) begin
      r = '0;
      r.rdata = rd_val;
      cycle_reqs.push_back(r);
    end
    foreach (cycle_reqs[k]) begin
      r = cycle_reqs[k];
      r.irq = hc_irq;
      r.bad_write = bad;
      r.last = (k == cycle_reqs.size() - 1);
      host_results_due.push_back(r);
    end
  endtask

  task automatic send_host_item(logic [1:0] kind, logic [2:0] sel, logic [7:0] w,
                                logic ok, logic [15:0] data);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_reg_sel <= sel;
    in_wdata <= w;
    in_resp_ok <= ok;
    in_resp_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_host_step(kind, sel, w, ok, data);
    items_sent++;
  endtask

  task automatic wr_reg(logic [2:0] sel, logic [7:0] w);
    send_host_item(KIND_WRITE, sel, w, 1'($urandom), 16'($urandom));
  endtask

  task automatic rd_reg(logic [2:0] sel);
    send_host_item(KIND_READ, sel, 8'($urandom), 1'($urandom), 16'($urandom));
  endtask

  task automatic respond(logic ok, logic [15:0] data);
    send_host_item(KIND_RESP, 3'($urandom), 8'($urandom), ok, data);
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (host_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dev_addr(logic [CFG_IDX_W-1:0] idx, logic [6:0] a);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_DEV) dev_tab[idx] = a;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_unmapped_access();
    wr_reg(REG_NONE, 8'hFF);
    rd_reg(REG_NONE);
    send_host_item(KIND_OTHER, REG_STATUS, 8'hFF, 1'b1, 16'hFFFF);
    respond(1'b1, 16'hFFFF);
  endtask

  task automatic test_absent_device();
    wr_reg(REG_ADDR, 8'h01);
    wr_reg(REG_CONTROL, CTL_EN | CTL_START | CYC_QUICK);
    rd_reg(REG_STATUS);
    wr_reg(REG_STATUS, 8'(ST_PRERR));
  endtask

  task automatic test_busy_cycle();
    wr_reg(REG_ADDR, {DEV_ADDR_RST[0], 1'b1});
    wr_reg(REG_CMD, 8'hFF);
    wr_reg(REG_CONTROL, CTL_EN | CTL_START | CYC_BYTE_DATA);
    wr_reg(REG_ADDR, 8'h00);
    wr_reg(REG_CONTROL, CTL_START | CYC_WORD);
    wr_reg(REG_CONTROL, CTL_EN);
    respond(1'b1, 16'hFFFF);
    rd_reg(REG_DATA0);
    rd_reg(REG_CONTROL);
    wr_reg(REG_CONTROL, CTL_ABORT | CTL_EN | CTL_START | CYC_QUICK);
    wr_reg(REG_STATUS, 8'hFF);
  endtask

  task automatic test_block_edges();
    wr_reg(REG_DATA0, 8'h00);
    wr_reg(REG_CONTROL, CTL_EN | CTL_START | CYC_BLOCK);
    wr_reg(REG_DATA0, 8'd3);
    wr_reg(REG_CONTROL, CTL_EN | CTL_START | CYC_BLOCK);
    respond(1'b1, 16'h00AA);
    respond(1'b0, 16'h0055);
    respond(1'b1, 16'hFF11);
    rd_reg(REG_BLOCK);
    wr_reg(REG_ADDR, {DEV_ADDR_RST[1], 1'b0});
    wr_reg(REG_CONTROL, CTL_START | CYC_BLOCK);
    wr_reg(REG_CONTROL, CTL_ABORT);
    wr_reg(REG_STATUS, 8'hFF);
  endtask

  task automatic test_reserved_types();
    wr_reg(REG_CONTROL, CTL_START | CYC_RSVD6);
    wr_reg(REG_CONTROL, 8'hC0 | CTL_START | CYC_RSVD7);
    rd_reg(REG_CONTROL);
  endtask

  task automatic test_full_block();
    wr_reg(REG_ADDR, {dev_tab[3], 1'b0});
    wr_reg(REG_CMD, 8'hF0);
    wr_reg(REG_BLOCK, 8'hFF);
    wr_reg(REG_BLOCK, 8'h00);
    wr_reg(REG_DATA0, 8'hFF);
    wr_reg(REG_CONTROL, CTL_EN | CTL_START | CYC_BLOCK);
    while (hc_busy) respond(1'b1, 16'($urandom));
    rd_reg(REG_STATUS);
    wr_reg(REG_STATUS, 8'hFF);
  endtask

  task automatic test_device_addresses();
    write_dev_addr(CFG_DEV0, 7'h00);
    write_dev_addr(CFG_DEV1, 7'h7F);
    write_dev_addr(CFG_DEV2, 7'h2A);
    write_dev_addr(CFG_DEV3, 7'h01);
    write_dev_addr(CFG_SPARE, 7'h7F);
    wr_reg(REG_ADDR, 8'h00);
    wr_reg(REG_CONTROL, CTL_START | CYC_QUICK);
    respond(1'b1, 16'h0000);
    wr_reg(REG_ADDR, 8'hFF);
    wr_reg(REG_CONTROL, CTL_EN | CTL_START | CYC_BYTE);
    respond(1'b0, 16'hFFFF);
    wr_reg(REG_ADDR, {DEV_ADDR_RST[0], 1'b0});
    wr_reg(REG_CONTROL, CTL_START | CYC_WORD);
    wr_reg(REG_STATUS, 8'hFF);
  endtask

  task automatic run_bus_cycle();
    logic [2:0] ctype;
    logic [6:0] hw;
    logic rd;
    logic [7:0] len;
    int roll;
    while (hc_busy) respond(1'b1, 16'($urandom));
    roll = $urandom_range(99);
    ctype = (roll < 6) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    hw = ($urandom_range(9) == 0) ? 7'($urandom) : dev_tab[$urandom_range(NUM_DEV - 1)];
    rd = 1'($urandom);
    wr_reg(REG_ADDR, {hw, rd});
    wr_reg(REG_CMD, 8'($urandom));
    if (ctype == CYC_BLOCK) begin
      len = ($urandom_range(19) == 0) ? 8'($urandom_range(32, 255)) : 8'($urandom_range(0, 6));
      if (!rd) repeat ($urandom_range(0, 4)) wr_reg(REG_BLOCK, 8'($urandom));
    end else begin
      len = 8'($urandom);
    end
    wr_reg(REG_DATA0, len);
    wr_reg(REG_DATA1, 8'($urandom));
    wr_reg(REG_CONTROL, {2'($urandom), 1'b0, 1'($urandom), 1'b1, ctype});
    while (hc_busy) begin
      roll = $urandom_range(99);
      if (roll < 3) wr_reg(REG_CONTROL, {2'($urandom), 1'b1, 5'($urandom)});
      else if (roll < 12) rd_reg(3'($urandom));
      else respond(roll >= 20, 16'($urandom));
    end
    repeat ($urandom_range(1, 3)) rd_reg(3'($urandom));
    wr_reg(REG_STATUS, 8'($urandom));
  endtask

  task automatic test_random_traffic(int n);
    int first;
    first = items_sent;
    while (items_sent - first < n) begin
      if ($urandom_range(99) < 75) run_bus_cycle();
      else send_host_item(2'($urandom_range(0, 2)), 3'($urandom), 8'($urandom),
                          1'($urandom), 16'($urandom));
    end
    while (hc_busy) respond(1'b1, 16'($urandom));
  endtask

  task automatic compare_field(string fname, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (host_results_due.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual req %b op %h rdata %h",
                 $time, out_req_valid, out_req_op, out_rdata);
        fail_count++;
      end else begin
        due_res = host_results_due.pop_front();
        compare_field("rdata", 16'(due_res.rdata), 16'(out_rdata));
        compare_field("req_valid", 16'(due_res.req_valid), 16'(out_req_valid));
        compare_field("req_op", 16'(due_res.req_op), 16'(out_req_op));
        compare_field("req_addr", 16'(due_res.req_addr), 16'(out_req_addr));
        compare_field("req_cmd", 16'(due_res.req_cmd), 16'(out_req_cmd));
        compare_field("req_data", due_res.req_data, out_req_data);
        compare_field("irq", 16'(due_res.irq), 16'(out_irq));
        compare_field("bad_write", 16'(due_res.bad_write), 16'(out_bad_write));
        compare_field("last", 16'(due_res.last), 16'(out_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_host_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unmapped_access();
    test_absent_device();
    test_busy_cycle();
    test_block_edges();
    test_reserved_types();
    test_full_block();
    test_random_traffic(25);

    // sender holds off until everything is back
    hold_until_drained();
    in_idle_pct = 69;
    out_idle_pct = 12;
    test_device_addresses();
    test_random_traffic(25);

    hold_until_drained();
    write_dev_addr(CFG_DEV0, 7'($urandom));
    write_dev_addr(CFG_DEV1, DEV_ADDR_RST[1]);
    write_dev_addr(CFG_DEV2, 7'($urandom));
    write_dev_addr(CFG_DEV3, 7'($urandom));
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_traffic(25);

    hold_until_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && host_results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/smbhc_pkg.sv
sv/smbhc_bbuf.sv
sv/smbhc_core.sv
sv/smbhc_burst.sv
sv/smbus_host_controller.sv
sim/testbench.sv
